// File: rtl/core/tkns_pkg.sv
// Package for the top-k nearest selector.
// Holds field widths, function codes, cell operation codes and the shared structs.
// No dependencies.
package tkns_pkg;

   localparam int DistW  = 32;
   localparam int IndexW = 24;
   localparam int CfgW   = 7;

   localparam logic [CfgW-1:0] TopKReset = 7'd16;

   localparam logic FUNC_OFFER = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REPLACE,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      logic              valid;
      logic [DistW-1:0]  distance;
      logic [IndexW-1:0] index;
   } entry_type;

   typedef struct packed {
      cell_op_type       op;
      logic [DistW-1:0]  distance;
      logic [IndexW-1:0] index;
   } cell_ctl_type;

endpackage

// File: rtl/core/tkns_if.sv
// Handshake interfaces for the request and response channels of the selector.
// Depends on tkns_pkg for the field widths.
interface tkns_req_if import tkns_pkg::*;;
   logic              valid;
   logic              ready;
   logic              func;
   logic [DistW-1:0]  cand_distance;
   logic [IndexW-1:0] cand_index;

   modport source (output valid, output func, output cand_distance, output cand_index,
                   input ready);
   modport sink (input valid, input func, input cand_distance, input cand_index,
                 output ready);
endinterface

interface tkns_rsp_if import tkns_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DistW-1:0]  out_distance;
   logic [IndexW-1:0] out_index;
   logic              is_last;
   logic              was_empty;

   modport source (output valid, output out_distance, output out_index, output is_last,
                   output was_empty, input ready);
   modport sink (input valid, input out_distance, input out_index, input is_last,
                 input was_empty, output ready);
endinterface

// File: rtl/core/tkns_cell.sv
// One cell of the sorted chain: holds one entry and exchanges it with its neighbors.
// Depends on tkns_pkg.
module tkns_cell import tkns_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    left_entry,
   input  logic         left_big,
   input  entry_type    right_entry,
   input  logic         right_big,
   output entry_type    entry_out,
   output logic         big_out
);

   logic              valid_ff, valid_in;
   logic [DistW-1:0]  dist_ff, dist_in;
   logic [IndexW-1:0] index_ff, index_in;
   logic              big;

   // The chain is kept in descending order, cell 0 holding the largest entry.
   assign big = valid_ff && (dist_ff > ctl.distance);

   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      index_in = index_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (!big) begin
               if (left_big) begin
                  valid_in = 1'b1;
                  dist_in  = ctl.distance;
                  index_in = ctl.index;
               end else begin
                  valid_in = left_entry.valid;
                  dist_in  = left_entry.distance;
                  index_in = left_entry.index;
               end
            end
         end
         CELL_REPLACE: begin
            if (right_big) begin
               dist_in  = right_entry.distance;
               index_in = right_entry.index;
            end else if (big) begin
               dist_in  = ctl.distance;
               index_in = ctl.index;
            end
         end
         CELL_SHIFT: begin
            valid_in = right_entry.valid;
            dist_in  = right_entry.distance;
            index_in = right_entry.index;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      dist_ff  <= dist_in;
      index_ff <= index_in;
   end

   assign entry_out = '{valid: valid_ff, distance: dist_ff, index: index_ff};
   assign big_out   = big;

endmodule

// File: rtl/core/top_k_nearest_selector_top.sv
// Top level of the top-k nearest selector: control, response register and the cell chain.
// Depends on tkns_pkg, tkns_if and tkns_cell.
// An offer word is taken every cycle while no drain is in progress.
// A drain word blocks the request side until its last result is loaded; the results are
// loaded into the response register from the drain state, one per cycle while rsp is ready,
// held_count results in all (one for an empty store), shifted out of cell 0 of the chain.
// Reset is synchronous: it clears the valid bits, the count and the control, and sets
// top_k to 16; there is no clearing pass.
module top_k_nearest_selector_top import tkns_pkg::*; #(
   parameter int K_MAX = 64
) (
   input  logic            clock,
   input  logic            reset,
   tkns_req_if.sink        req_ch,
   tkns_rsp_if.source      rsp_ch,
   input  logic            csr_we,
   input  logic [CfgW-1:0] csr_wdata
);

   localparam int CntW = $clog2(K_MAX + 1);
   localparam logic [CfgW-1:0] KMaxCfg = CfgW'(K_MAX);

   typedef enum logic {S_IDLE, S_DRAIN} state_type;

   state_type         state_ff, state_in;
   logic [CfgW-1:0]   top_k_ff, top_k_in;
   logic [CntW-1:0]   held_ff, held_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DistW-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [IndexW-1:0] rsp_index_ff, rsp_index_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_empty_ff, rsp_empty_in;

   cell_ctl_type      ctl;
   entry_type         entry_w [K_MAX];
   logic [K_MAX-1:0]  big_w;
   logic [K_MAX-1:0]  valid_w;
   logic [CfgW-1:0]   limit;
   logic              req_fire;
   logic              slot_free;
   logic              not_full;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (top_k_ff == '0) begin
         limit = CfgW'(1);
      end else if (top_k_ff > KMaxCfg) begin
         limit = KMaxCfg;
      end else begin
         limit = top_k_ff;
      end
   end

   assign not_full = CfgW'(held_ff) < limit;

   always_comb begin
      state_in     = state_ff;
      top_k_in     = csr_we ? csr_wdata : top_k_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      ctl.op       = CELL_HOLD;
      ctl.distance = req_ch.cand_distance;
      ctl.index    = req_ch.cand_index;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.func == FUNC_DRAIN) begin
                  state_in = S_DRAIN;
               end else if (not_full) begin
                  ctl.op  = CELL_INSERT;
                  held_in = held_ff + CntW'(1);
               end else if (big_w[0]) begin
                  ctl.op = CELL_REPLACE;
               end
            end
         end
         S_DRAIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (held_ff == '0) begin
                  rsp_dist_in  = '0;
                  rsp_index_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  ctl.op       = CELL_SHIFT;
                  rsp_dist_in  = entry_w[0].distance;
                  rsp_index_in = entry_w[0].index;
                  rsp_last_in  = (held_ff == CntW'(1));
                  rsp_empty_in = 1'b0;
                  held_in      = held_ff - CntW'(1);
                  if (held_ff == CntW'(1)) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_k_ff     <= TopKReset;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_k_ff     <= top_k_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_dist_ff  <= rsp_dist_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   for (genvar i = 0; i < K_MAX; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_big, right_big;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_big   = 1'b1;
      end else begin : g_inner_left
         assign left_entry = entry_w[i-1];
         assign left_big   = big_w[i-1];
      end

      if (i == K_MAX - 1) begin : g_last
         assign right_entry = '0;
         assign right_big   = 1'b0;
      end else begin : g_inner_right
         assign right_entry = entry_w[i+1];
         assign right_big   = big_w[i+1];
      end

      tkns_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .left_big    (left_big),
         .right_entry (right_entry),
         .right_big   (right_big),
         .entry_out   (entry_w[i]),
         .big_out     (big_w[i])
      );

      assign valid_w[i] = entry_w[i].valid;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_distance = rsp_dist_ff;
   assign rsp_ch.out_index    = rsp_index_ff;
   assign rsp_ch.is_last      = rsp_last_ff;
   assign rsp_ch.was_empty    = rsp_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CntW'(K_MAX))
      else $error("held count exceeds chain length");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_w) == int'(held_ff))
      else $error("cell valid bits disagree with held count");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_last_ff && (rsp_dist_ff == '0))
      else $error("empty drain word not marked last or carries data");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_ch.func == FUNC_OFFER) && not_full |=> held_ff == $past(held_ff) + 1'b1)
      else $error("insert into a non-full store did not grow the count");

endmodule
